// File: hw/rtl/tpd_pkg.sv
// Shared constants and types for the touch packet decoder.
`default_nettype none

package tpd_pkg;

  localparam int BYTE_W     = 8;
  localparam int RAW_W      = 15;
  localparam int SCALE_W    = 16;
  localparam int PROD_W     = RAW_W + SCALE_W;
  localparam int SCALE_SHIFT = 12;
  localparam int POS_W      = PROD_W - SCALE_SHIFT;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int POS_CNT_W  = 3;

  localparam logic [BYTE_W-1:0] PEN_DOWN_CODE = 8'h81;
  localparam logic [BYTE_W-1:0] PEN_UP_CODE   = 8'h80;
  localparam logic [BYTE_W-1:0] PEN_MASK_RST  = 8'h81;

  localparam logic [POS_CNT_W-1:0] LAST_POS = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_AXES_SWAPPED  = 2'd2,
    REG_PEN_BYTE_MASK = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [RAW_W-1:0] raw_w;
    logic [RAW_W-1:0] raw_h;
    logic             touched;
  } packet_t;

endpackage

`default_nettype wire

// File: hw/rtl/tpd_framer.sv
// Byte framing, pen byte check and raw axis assembly for the touch packet decoder.
`default_nettype none

module tpd_framer
  import tpd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [BYTE_W-1:0] in_byte,
  input  wire logic [BYTE_W-1:0] pen_mask,
  input  wire logic              swapped,
  output logic                   pkt_valid,
  input  wire logic              pkt_ready,
  output packet_t                pkt
);

  logic [POS_CNT_W-1:0] byte_pos;
  logic [BYTE_W-1:0]    held_pen;
  logic [BYTE_W-1:0]    held_x_low;
  logic [BYTE_W-1:0]    held_x_high;
  logic [BYTE_W-1:0]    held_y_low;
  logic                 accept;
  logic                 last_byte;
  logic [BYTE_W-1:0]    pen;
  logic                 pen_ok;
  logic [RAW_W-1:0]     raw_x;
  logic [RAW_W-1:0]     raw_y;
  packet_t              pkt_next;

  assign last_byte = (byte_pos == LAST_POS);
  assign in_ready  = !last_byte || !pkt_valid || pkt_ready;
  assign accept    = in_valid && in_ready;

  assign pen    = held_pen & pen_mask;
  assign pen_ok = (pen == PEN_DOWN_CODE) || (pen == PEN_UP_CODE);

  assign raw_x = {held_x_high, 7'd0} | {7'd0, held_x_low};
  assign raw_y = {in_byte, 7'd0} | {7'd0, held_y_low};

  always_comb begin
    pkt_next.raw_w   = swapped ? raw_y : raw_x;
    pkt_next.raw_h   = swapped ? raw_x : raw_y;
    pkt_next.touched = (pen == PEN_DOWN_CODE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos <= '0;
    end else if (accept) begin
      byte_pos <= last_byte ? '0 : byte_pos + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      case (byte_pos)
        3'd0:    held_pen    <= in_byte;
        3'd1:    held_x_low  <= in_byte;
        3'd2:    held_x_high <= in_byte;
        3'd3:    held_y_low  <= in_byte;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_valid <= 1'b0;
    end else if (accept && last_byte && pen_ok) begin
      pkt_valid <= 1'b1;
    end else if (pkt_ready) begin
      pkt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_byte && pen_ok) begin
      pkt <= pkt_next;
    end
  end

`ifndef ASSERT_OFF
  a_stall_only_on_last: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> byte_pos == LAST_POS)
    else $error("framer stalled away from the last byte");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_pos <= LAST_POS)
    else $error("byte position out of range");

  a_ready_without_pkt: assert property (@(posedge clk) disable iff (rst)
    !pkt_valid |-> in_ready)
    else $error("framer stalled with no packet pending");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/touch_packet_decoder.sv
// The framer registers each packet; a 15x16 multiplier per axis feeds the output registers.
// Throughput: one byte per cycle, except that a fifth byte waits while a packet waits on the output.
// A packet whose masked pen byte is neither pen down nor pen up gives no result.
// Reset (rst, synchronous): framing restarts, the previous result reads as x 0, y 0, pen up,
// width and height 0, axes not swapped, pen mask 0x81.
`default_nettype none

module touch_packet_decoder
  import tpd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [7:0]            s_axis_tdata,   // [7:0] rx_byte
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [39:0]                m_axis_tdata,   // [18:0] pos_x, [37:19] pos_y, zero pad
  output logic [1:0]                 m_axis_tuser,   // [0] touched, [1] changed
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [SCALE_W-1:0] screen_width;
  logic [SCALE_W-1:0] screen_height;
  logic               axes_swapped;
  logic [BYTE_W-1:0]  pen_byte_mask;

  logic               pkt_valid;
  logic               pkt_ready;
  packet_t            pkt;

  logic [PROD_W-1:0]  prod_w;
  logic [PROD_W-1:0]  prod_h;
  logic [POS_W-1:0]   pos_x;
  logic [POS_W-1:0]   pos_y;
  logic               touched;
  logic               changed;
  logic [POS_W-1:0]   pos_x_next;
  logic [POS_W-1:0]   pos_y_next;
  logic               changed_next;
  logic               out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= '0;
      screen_height <= '0;
      axes_swapped  <= 1'b0;
      pen_byte_mask <= PEN_MASK_RST;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        REG_AXES_SWAPPED:  axes_swapped  <= cfg_data[0];
        REG_PEN_BYTE_MASK: pen_byte_mask <= cfg_data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  tpd_framer u_framer (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_byte   (s_axis_tdata),
    .pen_mask  (pen_byte_mask),
    .swapped   (axes_swapped),
    .pkt_valid (pkt_valid),
    .pkt_ready (pkt_ready),
    .pkt       (pkt)
  );

  assign pkt_ready = !m_axis_tvalid || m_axis_tready;
  assign out_load  = pkt_valid && pkt_ready;

  assign prod_w = PROD_W'(pkt.raw_w) * PROD_W'(screen_width);
  assign prod_h = PROD_W'(pkt.raw_h) * PROD_W'(screen_height);

  assign pos_x_next   = prod_w[PROD_W-1:SCALE_SHIFT];
  assign pos_y_next   = prod_h[PROD_W-1:SCALE_SHIFT];
  assign changed_next = (pos_x_next != pos_x) || (pos_y_next != pos_y)
                        || (pkt.touched != touched);

  // Output registers double as the previous valid result.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      pos_x         <= '0;
      pos_y         <= '0;
      touched       <= 1'b0;
      changed       <= 1'b0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
        pos_x         <= pos_x_next;
        pos_y         <= pos_y_next;
        touched       <= pkt.touched;
        changed       <= changed_next;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  assign m_axis_tdata = {2'b00, pos_y, pos_x};
  assign m_axis_tuser = {changed, touched};

`ifndef ASSERT_OFF
  a_idle_after_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result offered right after reset");

  a_pkt_held: assert property (@(posedge clk) disable iff (rst)
    pkt_valid && !pkt_ready |=> pkt_valid && $stable(pkt))
    else $error("pending packet lost while output stalled");

  a_same_not_changed: assert property (@(posedge clk) disable iff (rst)
    out_load && (pos_x_next == pos_x) && (pos_y_next == pos_y)
    && (pkt.touched == touched) |=> !changed)
    else $error("changed flag set for a repeated result");
`endif

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for the touch packet decoder: directed and random report bytes, scored per transfer.
module testbench;
  import tpd_pkg::*;

  localparam int IDLE_PCT     = 22;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_BYTES = 1350;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int STEADY_FROM  = 1200;
  localparam int STEADY_TO    = 1800;
  localparam int HOLD_FROM    = 500;
  localparam int HOLD_CYCLES  = 300;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic             touched;
    logic             changed;
  } position_t;

  typedef enum logic [1:0] {
    OUT_PREDICT,
    OUT_NONE,
    OUT_ZERO
  } outcome_t;

  typedef struct {
    bit                    is_write;
    cfg_index_t            reg_idx;
    logic [CFG_DATA_W-1:0] value;
    outcome_t              outcome;
    logic                  touched;
    logic                  changed;
  } stim_row_t;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata;   // [7:0] rx_byte
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [39:0]           m_axis_tdata;   // [18:0] pos_x, [37:19] pos_y, zero pad
  logic [1:0]            m_axis_tuser;   // [0] touched, [1] changed
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  touch_packet_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  logic [SCALE_W-1:0]   width_q;
  logic [SCALE_W-1:0]   height_q;
  logic                 swap_q;
  logic [BYTE_W-1:0]    mask_q;
  logic [POS_CNT_W-1:0] frame_pos;
  logic [BYTE_W-1:0]    held [4];
  position_t            last_pos;

  position_t   expected_positions [$];
  int unsigned cycle_count = 0;
  int          errors = 0;
  int          bytes_taken = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic bit steady_now();
    return cycle_count >= STEADY_FROM && cycle_count < STEADY_TO;
  endfunction

  function automatic logic [POS_W-1:0] scaled(input logic [BYTE_W-1:0] hi,
                                              input logic [BYTE_W-1:0] lo,
                                              input logic [SCALE_W-1:0] factor);
    logic [RAW_W-1:0]  raw;
    logic [PROD_W-1:0] prod;
    raw  = (RAW_W'(hi) << 7) | RAW_W'(lo);
    prod = PROD_W'(raw) * PROD_W'(factor);
    return prod[PROD_W-1:SCALE_SHIFT];
  endfunction

  function automatic bit decode_byte(input logic [BYTE_W-1:0] b, output position_t r);
    logic [BYTE_W-1:0] pen;
    r = '0;
    if (frame_pos != LAST_POS) begin
      held[frame_pos[1:0]] = b;
      frame_pos = frame_pos + 3'd1;
      return 1'b0;
    end
    frame_pos = '0;
    pen = held[0] & mask_q;
    if (pen == PEN_DOWN_CODE) begin
      r.touched = 1'b1;
    end else if (pen == PEN_UP_CODE) begin
      r.touched = 1'b0;
    end else begin
      return 1'b0;
    end
    if (swap_q) begin
      r.x = scaled(b, held[3], width_q);
      r.y = scaled(held[2], held[1], height_q);
    end else begin
      r.x = scaled(held[2], held[1], width_q);
      r.y = scaled(b, held[3], height_q);
    end
    r.changed = r.x != last_pos.x || r.y != last_pos.y || r.touched != last_pos.touched;
    last_pos = r;
    return 1'b1;
  endfunction

  function automatic stim_row_t byte_row(input logic [7:0] b, input outcome_t o = OUT_PREDICT,
                                         input logic t = 1'b0, input logic c = 1'b0);
    stim_row_t row;
    row.is_write = 1'b0;
    row.reg_idx  = REG_SCREEN_WIDTH;
    row.value    = {8'd0, b};
    row.outcome  = o;
    row.touched  = t;
    row.changed  = c;
    return row;
  endfunction

  function automatic stim_row_t write_row(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] v);
    stim_row_t row;
    row = byte_row(8'd0);
    row.is_write = 1'b1;
    row.reg_idx  = idx;
    row.value    = v;
    return row;
  endfunction

  function automatic logic [7:0] pen_byte(input bit down);
    logic [7:0] code;
    code = down ? PEN_DOWN_CODE : PEN_UP_CODE;
    return (8'($urandom) & ~mask_q) | code;
  endfunction

  function automatic logic [7:0] coord_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_scale();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return CFG_DATA_W'($urandom_range(1, 16));
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  task automatic flag_mismatch(input string field, input logic [31:0] got, input logic [31:0] want);
    $display("%0t %s: got %0h, expected %0h", $time, field, got, want);
    errors++;
  endtask

  task automatic send_byte(input logic [7:0] b, input outcome_t o = OUT_PREDICT,
                           input logic t = 1'b0, input logic c = 1'b0);
    position_t r;
    bit        has;
    while (!steady_now() && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom);
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    bytes_taken++;
    has = decode_byte(b, r);
    if (o == OUT_ZERO) begin
      r = '0;
      r.touched = t;
      r.changed = c;
      expected_positions.push_back(r);
    end else if (o == OUT_PREDICT && has) begin
      expected_positions.push_back(r);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_positions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    case (idx)
      REG_SCREEN_WIDTH:  width_q = v;
      REG_SCREEN_HEIGHT: height_q = v;
      REG_AXES_SWAPPED:  swap_q = v[0];
      REG_PEN_BYTE_MASK: mask_q = v[BYTE_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    position_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_positions.size() == 0) begin
        flag_mismatch("transfer with none expected", m_axis_tdata[31:0], '0);
      end else begin
        want = expected_positions.pop_front();
        if (m_axis_tdata[POS_W-1:0] !== want.x)
          flag_mismatch("pos_x", 32'(m_axis_tdata[POS_W-1:0]), 32'(want.x));
        if (m_axis_tdata[2*POS_W-1:POS_W] !== want.y)
          flag_mismatch("pos_y", 32'(m_axis_tdata[2*POS_W-1:POS_W]), 32'(want.y));
        if (m_axis_tuser[0] !== want.touched)
          flag_mismatch("touched", 32'(m_axis_tuser[0]), 32'(want.touched));
        if (m_axis_tuser[1] !== want.changed)
          flag_mismatch("changed", 32'(m_axis_tuser[1]), 32'(want.changed));
      end
    end
  end

  initial begin
    int rx_cycles;
    rx_cycles = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cycles++;
      if (rx_cycles == HOLD_FROM) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_axis_tready <= steady_now() || $urandom_range(99) >= IDLE_PCT;
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("touch_packet_decoder: mismatch");
    $finish;
  end

  initial begin
    stim_row_t             directed_rows [$];
    logic [7:0]            last_pkt [5];
    bit                    have_last;
    int                    phase;
    int                    pick;
    logic [CFG_DATA_W-1:0] w;
    logic [CFG_DATA_W-1:0] h;
    logic [CFG_DATA_W-1:0] sw;
    logic [CFG_DATA_W-1:0] mk;

    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_SCREEN_WIDTH;
    cfg_data      <= '0;
    width_q   = '0;
    height_q  = '0;
    swap_q    = 1'b0;
    mask_q    = PEN_MASK_RST;
    frame_pos = '0;
    foreach (held[k]) held[k] = '0;
    last_pos  = '0;
    have_last = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    directed_rows = '{
      byte_row(8'hFF), byte_row(8'hFF), byte_row(8'hFF), byte_row(8'hFF),
      byte_row(8'hFF, OUT_ZERO, 1'b1, 1'b1),
      byte_row(8'hC0), byte_row(8'h00), byte_row(8'h00), byte_row(8'h00),
      byte_row(8'h00, OUT_ZERO, 1'b0, 1'b1),
      byte_row(8'h7E), byte_row(8'h12), byte_row(8'h34), byte_row(8'h56),
      byte_row(8'h78, OUT_NONE),
      write_row(REG_SCREEN_WIDTH, 16'hFFFF),
      write_row(REG_SCREEN_HEIGHT, 16'hFFFF),
      write_row(REG_PEN_BYTE_MASK, 16'h00FF),
      byte_row(8'h81), byte_row(8'hFF), byte_row(8'hFF), byte_row(8'hFF), byte_row(8'hFF),
      byte_row(8'h80), byte_row(8'h00), byte_row(8'h00), byte_row(8'h00),
      byte_row(8'h00, OUT_ZERO, 1'b0, 1'b1),
      byte_row(8'h81), byte_row(8'h55), byte_row(8'hAA), byte_row(8'h2A),
      write_row(REG_AXES_SWAPPED, 16'hFFFF),
      write_row(REG_PEN_BYTE_MASK, 16'hFF81),
      write_row(REG_SCREEN_HEIGHT, 16'h0001),
      byte_row(8'h80)
    };

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_write) begin
        drain();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
      end else begin
        send_byte(directed_rows[i].value[7:0], directed_rows[i].outcome,
                  directed_rows[i].touched, directed_rows[i].changed);
      end
    end

    bytes_taken = 0;
    phase = 0;
    while (bytes_taken < RANDOM_BYTES) begin
      drain();
      case (phase)
        0: begin
          w = '1; h = '1; sw = '0; mk = 16'h0081;
        end
        1: begin
          w = 16'd1; h = 16'd1; sw = '1; mk = {8'($urandom), 8'hFF};
        end
        2: begin
          w = '0; h = '1; sw = CFG_DATA_W'($urandom); mk = 16'h0081;
        end
        default: begin
          w  = pick_scale();
          h  = pick_scale();
          sw = CFG_DATA_W'($urandom);
          pick = $urandom_range(9);
          if (pick < 5) mk = {8'($urandom), 8'h81 | (8'($urandom) & 8'h7E)};
          else if (pick < 7) mk = {8'($urandom), 8'h81};
          else mk = CFG_DATA_W'($urandom);
        end
      endcase
      write_reg(REG_SCREEN_WIDTH, w);
      write_reg(REG_SCREEN_HEIGHT, h);
      write_reg(REG_AXES_SWAPPED, sw);
      write_reg(REG_PEN_BYTE_MASK, mk);

      repeat ($urandom_range(20, 50)) begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
        end else if (pick < 18) begin
          repeat (5) send_byte(8'($urandom));
        end else begin
          // realign framing before a clean packet
          while (frame_pos != 0) send_byte(8'($urandom));
          if (pick >= 33 || !have_last) begin
            last_pkt[0] = pen_byte(1'($urandom_range(1)));
            for (int k = 1; k < 5; k++) last_pkt[k] = coord_byte();
            have_last = 1'b1;
          end
          foreach (last_pkt[k]) send_byte(last_pkt[k]);
        end
      end
      phase++;
    end

    drain();
    if (errors == 0) begin
      $display("touch_packet_decoder: match");
    end else begin
      $display("touch_packet_decoder: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/tpd_pkg.sv
hw/rtl/tpd_framer.sv
hw/rtl/touch_packet_decoder.sv
tb/sv/testbench.sv
